// ===== hdl/pfbc_pkg.sv =====
// Shared types, constants and the twiddle table function of the channelizer.
package pfbc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int PROD_W   = 34;
    localparam int BIN_W    = 28;
    localparam int NUM_W    = 10;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_FIN,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_SUM,
        ST_BF_WA,
        ST_BF_WB
    } pfbc_state_t;

    function automatic logic [63:0] taylor_mul(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] prod;
        prod = term * x;
        return prod >> 30;
    endfunction

    // Quarter-wave cosine entry in unsigned Q0.17 from a truncated Taylor series in Q30.
    function automatic logic [16:0] quarter_cos(input logic [63:0] x);
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        term = 64'd1 << 30;
        sum  = $signed(term);
        term = taylor_mul(term, x) / 64'd1;
        term = taylor_mul(term, x) / 64'd2;
        sum  = sum - $signed(term);
        term = taylor_mul(term, x) / 64'd3;
        term = taylor_mul(term, x) / 64'd4;
        sum  = sum + $signed(term);
        term = taylor_mul(term, x) / 64'd5;
        term = taylor_mul(term, x) / 64'd6;
        sum  = sum - $signed(term);
        term = taylor_mul(term, x) / 64'd7;
        term = taylor_mul(term, x) / 64'd8;
        sum  = sum + $signed(term);
        term = taylor_mul(term, x) / 64'd9;
        term = taylor_mul(term, x) / 64'd10;
        sum  = sum - $signed(term);
        term = taylor_mul(term, x) / 64'd11;
        term = taylor_mul(term, x) / 64'd12;
        sum  = sum + $signed(term);
        term = taylor_mul(term, x) / 64'd13;
        term = taylor_mul(term, x) / 64'd14;
        sum  = sum - $signed(term);
        term = taylor_mul(term, x) / 64'd15;
        term = taylor_mul(term, x) / 64'd16;
        sum  = sum + $signed(term);
        term = taylor_mul(term, x) / 64'd17;
        term = taylor_mul(term, x) / 64'd18;
        sum  = sum - $signed(term);
        term = taylor_mul(term, x) / 64'd19;
        term = taylor_mul(term, x) / 64'd20;
        sum  = sum + $signed(term);
        term = taylor_mul(term, x) / 64'd21;
        term = taylor_mul(term, x) / 64'd22;
        sum  = sum - $signed(term);
        term = taylor_mul(term, x) / 64'd23;
        term = taylor_mul(term, x) / 64'd24;
        sum  = sum + $signed(term);
        r = (sum + 64'sd4096) >>> 13;
        if (r < 64'sd0) begin
            return 17'd0;
        end
        if (r > 64'sd131071) begin
            return 17'd131071;
        end
        return r[16:0];
    endfunction

endpackage

// ===== hdl/pfbc_twiddle_rom.sv =====
// Quarter-wave cosine table with two registered read ports.
module pfbc_twiddle_rom #(
    parameter int POINTS = 1024
) (
    input  logic                           aclk,
    input  logic [$clog2(POINTS/4+1)-1:0]  addr_a,
    input  logic [$clog2(POINTS/4+1)-1:0]  addr_b,
    output logic [16:0]                    data_a,
    output logic [16:0]                    data_b
);
    import pfbc_pkg::*;

    localparam int QTR = POINTS / 4;

    logic [16:0] tab [QTR+1];
    logic [16:0] data_a_reg;
    logic [16:0] data_b_reg;

    for (genvar g = 0; g <= QTR; g++) begin : g_tab
        localparam logic [63:0] XARG = (PI_Q30 * 64'd2 * 64'(g)) / 64'(POINTS);
        assign tab[g] = quarter_cos(XARG);
    end

    always_ff @(posedge aclk) begin
        data_a_reg <= tab[addr_a];
        data_b_reg <= tab[addr_b];
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

// ===== hdl/polyphase_filterbank_channelizer_core.sv =====
// Polyphase filter bank channelizer: per-branch FIR over memories and an iterative radix-2 DFT.
// A sample transaction multiplies each tap in turn in a shared multiply-accumulate unit reading
// one coefficient row and one history row. The sample that completes a frame then starts the
// in-place DFT over one frame memory with a single write port: each butterfly reads its two
// operands, multiplies, sums and writes its two results in turn before the next is read, and
// no transaction is accepted meanwhile. After reset the sample history is cleared, one row a
// cycle, before the first transaction is accepted.
module polyphase_filterbank_channelizer_core #(
    parameter int POINTS = 1024,
    parameter int TAPS   = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [15:0] s_sample_re,
    input  logic signed [15:0] s_sample_im,
    input  logic [9:0]         s_coef_branch,
    input  logic [1:0]         s_coef_tap,
    input  logic signed [17:0] s_coef_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [27:0] m_bin_re,
    output logic signed [27:0] m_bin_im,
    output logic [9:0]         m_bin_number,
    output logic               m_frame_end
);
    import pfbc_pkg::*;

    localparam int LOG_N = $clog2(POINTS);
    localparam int TW    = $clog2(TAPS);
    localparam int CW    = $clog2(TAPS + 1);
    localparam int HW    = (TAPS - 1) * 2 * SAMPLE_W;
    localparam int KW    = TAPS * COEF_W;
    localparam int ACC_W = PROD_W + TW;
    localparam int FW    = COEF_W + LOG_N + 2;
    localparam int PW    = FW + 20;
    localparam int SW    = $clog2(LOG_N);
    localparam int JW    = LOG_N - 1;
    localparam int QTR   = POINTS / 4;
    localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(65536);
    localparam logic signed [PW-1:0]    HALF_P   = PW'(65536);

    pfbc_state_t state_reg, state_next;

    logic [HW-1:0]   hist_mem [POINTS];
    logic [KW-1:0]   coef_mem [POINTS];
    logic [2*FW-1:0] frame_mem [2*POINTS];

    logic [HW-1:0]   hist_rd_reg;
    logic [KW-1:0]   coef_rd_reg;
    logic [2*FW-1:0] fa_rd_reg;
    logic [2*FW-1:0] fb_rd_reg;

    logic [LOG_N-1:0] clr_idx_reg;
    logic [LOG_N-1:0] pos_reg;
    logic             sel_reg;
    logic             bins_ready_reg;
    logic [CW-1:0]    cnt_reg;
    logic [SW-1:0]    stage_reg;
    logic [JW-1:0]    bf_idx_reg;

    logic signed [15:0]      samp_re_reg, samp_im_reg;
    logic signed [PROD_W-1:0] prod_re_reg, prod_im_reg;
    logic signed [ACC_W-1:0] acc_re_reg, acc_im_reg;

    logic [LOG_N-1:0] a_addr_reg, b_addr_reg;
    logic             q_reg, mzero_reg;
    logic signed [FW+18:0] p_rr_reg, p_is_reg, p_ic_reg, p_rs_reg;
    logic signed [FW-1:0]  t_re_reg, t_im_reg;

    logic               m_valid_reg;
    logic signed [27:0] m_re_reg, m_im_reg;
    logic [9:0]         m_num_reg;
    logic               m_end_reg;

    logic acc_in, samp_go, coef_go, out_free, fin_go, bf_last, stage_last, clr_last;
    logic hist_we, frame_we;
    logic [LOG_N-1:0] hist_waddr;
    logic [HW-1:0]    hist_wdata;
    logic [LOG_N:0]   frame_waddr;
    logic [2*FW-1:0]  frame_wdata;
    logic [LOG_N:0]   fa_raddr, fb_raddr;
    logic             fa_re, fb_re;

    logic signed [15:0]        x_re_sel, x_im_sel;
    logic signed [COEF_W-1:0]  c_sel;
    logic signed [ACC_W-1:0]   rnd_re, rnd_im;
    logic signed [COEF_W-1:0]  sat_re, sat_im;
    logic [LOG_N-1:0]          pos_rev;
    logic [HW-1:0]             hist_new;

    logic [JW-1:0]    mask, k_idx, m_tw;
    logic [LOG_N-1:0] a_addr, b_addr;
    logic [JW-1:0]    rom_a, rom_b;
    logic [16:0]      rom_da, rom_db;
    logic signed [18:0] c_tw, s_tw;
    logic signed [FW-1:0] a_re, a_im, b_re, b_im;
    logic signed [PW-1:0] sum_re, sum_im;
    logic signed [63:0]   bin_re_ext, bin_im_ext, rnd_re_ext, rnd_im_ext;

    assign acc_in     = s_valid && s_ready;
    assign samp_go    = acc_in && !s_op;
    assign coef_go    = acc_in && s_op && (32'(s_coef_branch) < POINTS) && (32'(s_coef_tap) < TAPS);
    assign out_free   = !m_valid_reg || m_ready;
    assign fin_go     = (state_reg == ST_FIN) && (!bins_ready_reg || out_free);
    assign bf_last    = (bf_idx_reg == '1);
    assign stage_last = (stage_reg == SW'(LOG_N - 1));
    assign clr_last   = (clr_idx_reg == '1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_last) state_next = ST_IDLE;
            ST_IDLE:   if (samp_go) state_next = ST_MAC;
            ST_MAC:    if (cnt_reg == CW'(TAPS)) state_next = ST_FIN;
            ST_FIN: begin
                if (fin_go) begin
                    state_next = (pos_reg == '1) ? ST_BF_RD : ST_IDLE;
                end
            end
            ST_BF_RD:  state_next = ST_BF_MUL;
            ST_BF_MUL: state_next = ST_BF_SUM;
            ST_BF_SUM: state_next = ST_BF_WA;
            ST_BF_WA:  state_next = ST_BF_WB;
            ST_BF_WB:  state_next = (bf_last && stage_last) ? ST_IDLE : ST_BF_RD;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Butterfly addressing and twiddle index.
    always_comb begin
        mask   = (JW'(1) << stage_reg) - JW'(1);
        k_idx  = bf_idx_reg & mask;
        a_addr = ({1'b0, bf_idx_reg & ~mask} << 1) | {1'b0, k_idx};
        b_addr = a_addr | (LOG_N'(1) << stage_reg);
        m_tw   = k_idx << (SW'(LOG_N - 1) - stage_reg);
        rom_a  = {1'b0, m_tw[JW-2:0]};
        rom_b  = JW'(QTR) - {1'b0, m_tw[JW-2:0]};
    end

    pfbc_twiddle_rom #(
        .POINTS(POINTS)
    ) u_rom (
        .aclk   (aclk),
        .addr_a (rom_a),
        .addr_b (rom_b),
        .data_a (rom_da),
        .data_b (rom_db)
    );

    always_comb begin
        for (int i = 0; i < LOG_N; i++) begin
            pos_rev[i] = pos_reg[LOG_N-1-i];
        end
    end

    always_comb begin
        x_re_sel = samp_re_reg;
        x_im_sel = samp_im_reg;
        c_sel    = coef_rd_reg[COEF_W-1:0];
        for (int i = 1; i < TAPS; i++) begin
            if (cnt_reg == CW'(i)) begin
                x_re_sel = hist_rd_reg[(i-1)*32 +: 16];
                x_im_sel = hist_rd_reg[(i-1)*32+16 +: 16];
                c_sel    = coef_rd_reg[i*COEF_W +: COEF_W];
            end
        end
    end

    always_comb begin
        rnd_re     = (acc_re_reg + HALF_ACC) >>> 17;
        rnd_im     = (acc_im_reg + HALF_ACC) >>> 17;
        rnd_re_ext = 64'(rnd_re);
        rnd_im_ext = 64'(rnd_im);
        if (rnd_re_ext > 64'sd131071) begin
            sat_re = 18'sd131071;
        end else if (rnd_re_ext < -64'sd131072) begin
            sat_re = -18'sd131072;
        end else begin
            sat_re = rnd_re[COEF_W-1:0];
        end
        if (rnd_im_ext > 64'sd131071) begin
            sat_im = 18'sd131071;
        end else if (rnd_im_ext < -64'sd131072) begin
            sat_im = -18'sd131072;
        end else begin
            sat_im = rnd_im[COEF_W-1:0];
        end
        hist_new = HW'({hist_rd_reg, samp_im_reg, samp_re_reg});
    end

    always_comb begin
        a_re   = $signed(fa_rd_reg[FW-1:0]);
        a_im   = $signed(fa_rd_reg[2*FW-1:FW]);
        b_re   = $signed(fb_rd_reg[FW-1:0]);
        b_im   = $signed(fb_rd_reg[2*FW-1:FW]);
        c_tw   = q_reg ? -$signed({2'b00, rom_db}) : $signed({2'b00, rom_da});
        s_tw   = q_reg ? $signed({2'b00, rom_da}) : $signed({2'b00, rom_db});
        sum_re = PW'(p_rr_reg) + PW'(p_is_reg) + HALF_P;
        sum_im = PW'(p_ic_reg) - PW'(p_rs_reg) + HALF_P;
        bin_re_ext = 64'(a_re);
        bin_im_ext = 64'(a_im);
    end

    // Memory controls.
    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        hist_we     = 1'b0;
        hist_waddr  = pos_reg;
        hist_wdata  = hist_new;
        frame_we    = 1'b0;
        frame_waddr = {sel_reg, pos_rev};
        frame_wdata = {FW'(sat_im), FW'(sat_re)};
        fa_re       = 1'b0;
        fb_re       = 1'b0;
        fa_raddr    = {!sel_reg, pos_reg};
        fb_raddr    = {sel_reg, b_addr};
        unique case (state_reg)
            ST_CLEAR: begin
                hist_we    = 1'b1;
                hist_waddr = clr_idx_reg;
                hist_wdata = '0;
            end
            ST_IDLE: begin
                fa_re = samp_go;
            end
            ST_FIN: begin
                hist_we  = fin_go;
                frame_we = fin_go;
            end
            ST_BF_RD: begin
                fa_re    = 1'b1;
                fb_re    = 1'b1;
                fa_raddr = {sel_reg, a_addr};
            end
            ST_BF_WA: begin
                frame_we    = 1'b1;
                frame_waddr = {sel_reg, a_addr_reg};
                frame_wdata = {a_im + t_im_reg, a_re + t_re_reg};
            end
            ST_BF_WB: begin
                frame_we    = 1'b1;
                frame_waddr = {sel_reg, b_addr_reg};
                frame_wdata = {a_im - t_im_reg, a_re - t_re_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (samp_go) begin
            hist_rd_reg <= hist_mem[pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (coef_go) begin
            coef_mem[LOG_N'(s_coef_branch)][TW'(s_coef_tap)*COEF_W +: COEF_W] <= s_coef_value;
        end
        if (samp_go) begin
            coef_rd_reg <= coef_mem[pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        if (fa_re) begin
            fa_rd_reg <= frame_mem[fa_raddr];
        end
        if (fb_re) begin
            fb_rd_reg <= frame_mem[fb_raddr];
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (samp_go) begin
            samp_re_reg <= s_sample_re;
            samp_im_reg <= s_sample_im;
        end
        if (state_reg == ST_MAC) begin
            if (cnt_reg < CW'(TAPS)) begin
                prod_re_reg <= x_re_sel * c_sel;
                prod_im_reg <= x_im_sel * c_sel;
            end
            if (cnt_reg == CW'(1)) begin
                acc_re_reg <= ACC_W'(prod_re_reg);
                acc_im_reg <= ACC_W'(prod_im_reg);
            end else if (cnt_reg != '0) begin
                acc_re_reg <= acc_re_reg + ACC_W'(prod_re_reg);
                acc_im_reg <= acc_im_reg + ACC_W'(prod_im_reg);
            end
        end
        if (state_reg == ST_BF_RD) begin
            a_addr_reg <= a_addr;
            b_addr_reg <= b_addr;
            q_reg      <= m_tw[JW-1];
            mzero_reg  <= (m_tw == '0);
        end
        if (state_reg == ST_BF_MUL) begin
            p_rr_reg <= b_re * c_tw;
            p_is_reg <= b_im * s_tw;
            p_ic_reg <= b_im * c_tw;
            p_rs_reg <= b_re * s_tw;
        end
        if (state_reg == ST_BF_SUM) begin
            t_re_reg <= mzero_reg ? b_re : FW'(sum_re >>> 17);
            t_im_reg <= mzero_reg ? b_im : FW'(sum_im >>> 17);
        end
        if (fin_go && bins_ready_reg) begin
            if (bin_re_ext > 64'sd134217727) begin
                m_re_reg <= 28'sd134217727;
            end else if (bin_re_ext < -64'sd134217728) begin
                m_re_reg <= -28'sd134217728;
            end else begin
                m_re_reg <= bin_re_ext[BIN_W-1:0];
            end
            if (bin_im_ext > 64'sd134217727) begin
                m_im_reg <= 28'sd134217727;
            end else if (bin_im_ext < -64'sd134217728) begin
                m_im_reg <= -28'sd134217728;
            end else begin
                m_im_reg <= bin_im_ext[BIN_W-1:0];
            end
            m_num_reg <= NUM_W'(pos_reg);
            m_end_reg <= (pos_reg == '1);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            pos_reg        <= '0;
            sel_reg        <= 1'b0;
            bins_ready_reg <= 1'b0;
            cnt_reg        <= '0;
            stage_reg      <= '0;
            bf_idx_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + LOG_N'(1);
            end
            if (samp_go) begin
                cnt_reg <= '0;
            end else if (state_reg == ST_MAC) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (fin_go && bins_ready_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (fin_go) begin
                pos_reg <= pos_reg + LOG_N'(1);
                if (pos_reg == '1) begin
                    stage_reg  <= '0;
                    bf_idx_reg <= '0;
                end
            end
            if (state_reg == ST_BF_WB) begin
                bf_idx_reg <= bf_idx_reg + JW'(1);
                if (bf_last) begin
                    stage_reg <= stage_reg + SW'(1);
                    if (stage_last) begin
                        sel_reg        <= !sel_reg;
                        bins_ready_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_bin_re     = m_re_reg;
    assign m_bin_im     = m_im_reg;
    assign m_bin_number = m_num_reg;
    assign m_frame_end  = m_end_reg;

    a_rise_fin : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN) && bins_ready_reg)
        else $error("result raised outside the finish step");

    a_bf_pos : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BF_WB) |-> (pos_reg == '0))
        else $error("butterfly running while a frame is partly filled");

    a_clear_quiet : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !bins_ready_reg && !m_valid_reg)
        else $error("activity during the history clear");

    a_dft_done : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BF_WB) && bf_last && stage_last |=> $changed(sel_reg))
        else $error("bank select did not swap after the transform");

endmodule

// ===== sim/bin_checker.sv =====
// Checker that predicts channelizer bins from accepted transactions and compares them.
module bin_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_op,
    input  logic signed [15:0] s_sample_re,
    input  logic signed [15:0] s_sample_im,
    input  logic [9:0]         s_coef_branch,
    input  logic [1:0]         s_coef_tap,
    input  logic signed [17:0] s_coef_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [27:0] m_bin_re,
    input  logic signed [27:0] m_bin_im,
    input  logic [9:0]         m_bin_number,
    input  logic               m_frame_end,
    output int                 errors,
    output int                 pending,
    output int                 bins_seen,
    output int                 frames_done
);
    import pfbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPT = 1024;
    localparam int NTAP = 4;
    localparam int QTR = NPT / 4;
    localparam int LOG2N = 10;
    localparam longint SUM_MAX = 131071;
    localparam longint SUM_MIN = -131072;
    localparam longint BIN_MAX = 134217727;
    localparam longint BIN_MIN = -134217728;

    typedef struct {
        logic signed [27:0] re;
        logic signed [27:0] im;
        logic [9:0]         num;
        logic               last;
    } bin_t;

    bin_t   expected_bins[$];
    longint hist_re[NPT*(NTAP-1)];
    longint hist_im[NPT*(NTAP-1)];
    longint coefs[NPT*NTAP];
    longint branch_re[NPT];
    longint branch_im[NPT];
    longint spec_re[NPT];
    longint spec_im[NPT];
    longint cos_q[QTR+1];
    int     position;
    bit     spectrum_valid;

    function automatic longint round_by(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint cos_entry(int j);
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        x = (longint'(PI_Q30) * 2 * j) / NPT;
        term = 64'd1 << 30;
        acc = term;
        for (int n = 1; n <= 24; n++) begin
            term = ((term * x) >> 30) / n;
            if (n % 4 == 2) begin
                acc -= term;
            end else if (n % 4 == 0) begin
                acc += term;
            end
        end
        return sat(round_by(acc, 13), 0, 131071);
    endfunction

    function automatic void transform();
        int     r;
        int     half;
        int     stride;
        int     m;
        int     ia;
        int     ib;
        longint c;
        longint s;
        longint a0;
        longint b0;
        longint tr;
        longint ti;
        for (int i = 0; i < NPT; i++) begin
            r = 0;
            for (int k = 0; k < LOG2N; k++) begin
                r = (r << 1) | ((i >> k) & 1);
            end
            spec_re[r] = branch_re[i];
            spec_im[r] = branch_im[i];
        end
        for (int len = 2; len <= NPT; len *= 2) begin
            half = len / 2;
            stride = NPT / len;
            for (int st = 0; st < NPT; st += len) begin
                for (int k = 0; k < half; k++) begin
                    ia = st + k;
                    ib = st + k + half;
                    tr = spec_re[ib];
                    ti = spec_im[ib];
                    m = k * stride;
                    if (m != 0) begin
                        a0 = cos_q[m % QTR];
                        b0 = cos_q[QTR - (m % QTR)];
                        case ((m / QTR) & 3)
                            0: begin c = a0;  s = b0;  end
                            1: begin c = -b0; s = a0;  end
                            2: begin c = -a0; s = -b0; end
                            default: begin c = b0; s = -a0; end
                        endcase
                        tr = round_by(spec_re[ib] * c + spec_im[ib] * s, 17);
                        ti = round_by(spec_im[ib] * c - spec_re[ib] * s, 17);
                    end
                    spec_re[ib] = spec_re[ia] - tr;
                    spec_im[ib] = spec_im[ia] - ti;
                    spec_re[ia] = spec_re[ia] + tr;
                    spec_im[ia] = spec_im[ia] + ti;
                end
            end
        end
    endfunction

    initial begin
        for (int j = 0; j <= QTR; j++) begin
            cos_q[j] = cos_entry(j);
        end
        errors = 0;
        pending = 0;
        bins_seen = 0;
        frames_done = 0;
    end

    always @(posedge aclk) begin
        bin_t   got;
        bin_t   exp_bin;
        longint acc_re;
        longint acc_im;
        longint c;
        int     base;
        if (!aresetn) begin
            foreach (hist_re[i]) begin
                hist_re[i] = 0;
                hist_im[i] = 0;
            end
            foreach (coefs[i]) begin
                coefs[i] = 0;
            end
            position = 0;
            spectrum_valid = 0;
            expected_bins.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.re = m_bin_re;
                got.im = m_bin_im;
                got.num = m_bin_number;
                got.last = m_frame_end;
                bins_seen++;
                if (expected_bins.size() == 0) begin
                    errors++;
                    $error("Unexpected bin transaction, bin_number %0d", got.num);
                end else begin
                    exp_bin = expected_bins.pop_front();
                    if (got.re !== exp_bin.re) begin
                        errors++;
                        $error("bin_re expected %0d got %0d", exp_bin.re, got.re);
                    end
                    if (got.im !== exp_bin.im) begin
                        errors++;
                        $error("bin_im expected %0d got %0d", exp_bin.im, got.im);
                    end
                    if (got.num !== exp_bin.num) begin
                        errors++;
                        $error("bin_number expected %0d got %0d", exp_bin.num, got.num);
                    end
                    if (got.last !== exp_bin.last) begin
                        errors++;
                        $error("frame_end expected %0d got %0d", exp_bin.last, got.last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_op) begin
                    coefs[s_coef_branch * NTAP + s_coef_tap] = longint'(s_coef_value);
                end else begin
                    base = position * (NTAP - 1);
                    c = coefs[position * NTAP];
                    acc_re = longint'(s_sample_re) * c;
                    acc_im = longint'(s_sample_im) * c;
                    for (int t = 1; t < NTAP; t++) begin
                        c = coefs[position * NTAP + t];
                        acc_re += hist_re[base + t - 1] * c;
                        acc_im += hist_im[base + t - 1] * c;
                    end
                    for (int t = NTAP - 1; t > 1; t--) begin
                        hist_re[base + t - 1] = hist_re[base + t - 2];
                        hist_im[base + t - 1] = hist_im[base + t - 2];
                    end
                    hist_re[base] = longint'(s_sample_re);
                    hist_im[base] = longint'(s_sample_im);
                    branch_re[position] = sat(round_by(acc_re, 17), SUM_MIN, SUM_MAX);
                    branch_im[position] = sat(round_by(acc_im, 17), SUM_MIN, SUM_MAX);
                    if (spectrum_valid) begin
                        exp_bin.re = 28'(sat(spec_re[position], BIN_MIN, BIN_MAX));
                        exp_bin.im = 28'(sat(spec_im[position], BIN_MIN, BIN_MAX));
                        exp_bin.num = 10'(position);
                        exp_bin.last = (position == NPT - 1);
                        expected_bins.push_back(exp_bin);
                    end
                    position++;
                    if (position >= NPT) begin
                        transform();
                        spectrum_valid = 1;
                        frames_done++;
                        position = 0;
                    end
                end
            end
        end
        pending = expected_bins.size();
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the channelizer testbench: clock, reset, stimulus, stall patterns and verdict.
module testbench;
    import pfbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPT = 1024;
    localparam int NTAP = 4;
    localparam int SAMPLES = 2100;
    localparam int IDLE_LIMIT = 200000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_op;
    logic signed [15:0] s_sample_re;
    logic signed [15:0] s_sample_im;
    logic [9:0]         s_coef_branch;
    logic [1:0]         s_coef_tap;
    logic signed [17:0] s_coef_value;
    logic               m_valid;
    logic               m_ready;
    logic signed [27:0] m_bin_re;
    logic signed [27:0] m_bin_im;
    logic [9:0]         m_bin_number;
    logic               m_frame_end;
    int                 errors;
    int                 pending;
    int                 bins_seen;
    int                 frames_done;
    int                 idle_cycles;
    int                 coef_writes;
    int                 samples_sent;
    bit                 long_hold_done;

    polyphase_filterbank_channelizer_core DUT (.*);

    bin_checker u_checker (.*);

    initial begin
        aclk = 0;
    end

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap(int busy_pct);
        if ($urandom_range(0, 99) < busy_pct) begin
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(20, 60);
        end
        return $urandom_range(1, 4);
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic signed [17:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 18'sh20000;
            1: return 18'sh1ffff;
            2: return 18'sh00000;
            default: return 18'($urandom_range(0, 262143));
        endcase
    endfunction

    task automatic send_item(input logic op, input logic signed [15:0] re,
                             input logic signed [15:0] im, input logic [9:0] branch,
                             input logic [1:0] tap, input logic signed [17:0] value,
                             input int gap);
        s_valid <= 1'b1;
        s_op <= op;
        s_sample_re <= re;
        s_sample_im <= im;
        s_coef_branch <= branch;
        s_coef_tap <= tap;
        s_coef_value <= value;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (op) begin
            coef_writes++;
        end else begin
            samples_sent++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && bins_seen >= 50) begin
                long_hold_done = 1;
                m_ready <= 1'b0;
                repeat (2000) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            m_ready <= 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(20, 80)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
        end
    end

    initial begin
        logic signed [17:0] value;
        int                 busy;
        bit                 drained;
        s_valid = 1'b0;
        s_op = 1'b0;
        s_sample_re = '0;
        s_sample_im = '0;
        s_coef_branch = '0;
        s_coef_tap = '0;
        s_coef_value = '0;
        aresetn = 1'b0;
        idle_cycles = 0;
        coef_writes = 0;
        samples_sent = 0;
        long_hold_done = 0;
        drained = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Every coefficient is loaded first; a few branches carry full-scale windows.
        for (int b = 0; b < NPT; b++) begin
            for (int t = 0; t < NTAP; t++) begin
                if (b == 0) begin
                    value = 18'sh20000;
                end else if (b == 1) begin
                    value = 18'sh1ffff;
                end else if (b == 2) begin
                    value = (t == 0) ? 18'sh1ffff : 18'sh0;
                end else begin
                    value = pick_coef();
                end
                busy = (b < NPT / 2) ? 100 : 80;
                send_item(1'b1, pick_sample(), pick_sample(), 10'(b), 2'(t), value,
                          pick_gap(busy));
            end
        end

        send_item(1'b0, 16'sh8000, 16'sh8000, '1, '1, '0, 0);
        send_item(1'b0, 16'sh7fff, 16'sh7fff, '0, '0, '1, 0);
        send_item(1'b0, 16'sh0000, 16'sh0000, '0, '0, '0, 0);
        send_item(1'b0, 16'sh7fff, 16'sh8000, '0, '0, '0, 1);
        send_item(1'b0, 16'shffff, 16'sh0001, '0, '0, '0, 0);
        send_item(1'b1, '0, '0, 10'd3, 2'd3, 18'sh20000, 0);
        send_item(1'b1, '0, '0, 10'd1023, 2'd0, 18'sh1ffff, 0);

        while (samples_sent < SAMPLES) begin
            busy = ((samples_sent / 200) % 2 == 0) ? 100 : 60;
            if (samples_sent == 1500 && !drained) begin
                drained = 1;
                s_valid <= 1'b0;
                do begin
                    @(posedge aclk);
                end while (pending != 0);
            end
            if ($urandom_range(0, 19) == 0) begin
                send_item(1'b1, pick_sample(), pick_sample(), 10'($urandom_range(0, NPT - 1)),
                          2'($urandom_range(0, NTAP - 1)), pick_coef(), pick_gap(busy));
            end else begin
                send_item(1'b0, pick_sample(), pick_sample(), 10'($urandom_range(0, 1023)),
                          2'($urandom_range(0, 3)), 18'($urandom_range(0, 262143)),
                          pick_gap(busy));
            end
        end
        s_valid <= 1'b0;

        do begin
            @(posedge aclk);
        end while (pending != 0);
        repeat (100) @(posedge aclk);
        $display("Sent %0d coefficient writes and %0d samples through %0d transforms.",
                 coef_writes, samples_sent, frames_done);
        $display("Checked %0d bins under random stalls on both channels.", bins_seen);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pfbc_pkg.sv
hdl/pfbc_twiddle_rom.sv
hdl/polyphase_filterbank_channelizer_core.sv
sim/bin_checker.sv
sim/testbench.sv
